// ===== src/mfne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file note extractor package
// Shared types and constants for the byte parser and the note record stage.
// ----------------------------------------------------------------------------
package mfne_pkg;

  localparam int unsigned VoiceLimit = 5;
  localparam logic [2:0] VOICE_MAX = (VoiceLimit > 7) ? 3'd7 : 3'(VoiceLimit);
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_SYSEX_E = 8'hF7;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [3:0] HI_NOTE_ON = 4'h9;
  localparam logic [3:0] HI_PROGRAM = 4'hC;
  localparam logic [3:0] HI_PRESS   = 4'hD;

  // Note event handed from the parser to the record stage.
  typedef struct packed {
    logic [31:0] ticks;
    logic [6:0]  note;
    logic        restart;
  } note_evt_t;

endpackage

// ===== src/midi_file_note_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file note extractor
// Parses a Standard MIDI File byte stream and emits note-on records.
// ----------------------------------------------------------------------------
// Input channel: file_byte and file_start with valid/stall; one byte is taken
// per cycle while stall is low. file_start marks header byte 0 of a new file.
// Output channel: time_slot, voice_index, pitch_class, octave with
// out_valid/out_stall; one record per note-on of nonzero velocity while
// cfg record_enable is 1.
// The parser decodes one byte per cycle while stall is low. From the velocity
// byte, records pass the event register, queue write, queue read, reciprocal
// multiply dividing by 96, then slot and voice update to the output register.
// Sustained throughput is one byte per cycle without out_stall. A four-entry
// queue separates parser and record stage; in_stall rises when it holds two or
// more events, so a stalled receiver stops input once two events are queued.
// Synchronous reset clears the parser, tick total, slot tracking and queue
// and sets record_enable to 1. Configuration is written through cfg_valid
// and cfg_ready; cfg_ready is always high.
// ----------------------------------------------------------------------------
module midi_file_note_extractor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] time_slot,
  output logic [2:0]  voice_index,
  output logic [3:0]  pitch_class,
  output logic [3:0]  octave,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import mfne_pkg::*;

  logic      record_enable, room, take, evt_valid;
  note_evt_t evt;

  assign cfg_ready = 1'b1;
  assign in_stall = !room;
  assign take = in_valid && room;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) record_enable <= 1'b1;
    else if (cfg_valid && cfg_ready) record_enable <= cfg_data;
  end

  mfne_parser u_parser (
    .clk, .rst, .file_byte, .file_start, .take, .record_enable,
    .evt_valid, .evt
  );

  mfne_record u_record (
    .clk, .rst, .evt_valid, .evt, .room, .valid(out_valid), .stall(out_stall),
    .time_slot, .voice_index, .pitch_class, .octave
  );
endmodule

// ===== src/mfne_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file byte parser
// Walks header, track headers and events one byte per cycle while take is
// high; passes restart marks and, when enabled, nonzero-velocity note-ons.
// ----------------------------------------------------------------------------
module mfne_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          file_byte,
  input  logic                file_start,
  input  logic                take,
  input  logic                record_enable,
  output logic                evt_valid,
  output mfne_pkg::note_evt_t evt
);
  import mfne_pkg::*;

  typedef enum logic [9:0] {
    PH_FILE_HDR  = 10'b0000000001,
    PH_TRK_HDR   = 10'b0000000010,
    PH_DELTA     = 10'b0000000100,
    PH_STATUS    = 10'b0000001000,
    PH_META_TYPE = 10'b0000010000,
    PH_LENGTH    = 10'b0000100000,
    PH_SKIP      = 10'b0001000000,
    PH_NOTE_NUM  = 10'b0010000000,
    PH_NOTE_VEL  = 10'b0100000000,
    PH_DONE      = 10'b1000000000
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [3:0]  hpos, hpos_next;
  logic [15:0] tracks, tracks_next;
  logic [31:0] tbytes, tbytes_next, acc, acc_next, skip, skip_next;
  logic [31:0] ticks, ticks_next;
  logic [6:0]  note, note_next;
  logic [32:0] sum;
  logic [31:0] tb;
  logic        evt_next, restart_next, count;

  // Next-state decode for one byte.
  always_comb begin
    ph = file_start ? PH_FILE_HDR : phase;
    hpos_next = file_start ? 4'd0 : hpos;
    tracks_next = file_start ? 16'd0 : tracks;
    tbytes_next = file_start ? 32'd0 : tbytes;
    acc_next = file_start ? 32'd0 : acc;
    skip_next = file_start ? 32'd0 : skip;
    ticks_next = file_start ? 32'd0 : ticks;
    note_next = file_start ? 7'd0 : note;
    phase_next = ph;
    evt_next = 1'b0;
    restart_next = file_start;
    count = 1'b1;
    sum = {1'b0, ticks_next} + {1'b0, acc_next[24:0], file_byte[6:0]};
    unique case (ph)
      PH_FILE_HDR: begin
        count = 1'b0;
        if (hpos_next == 4'd10) tracks_next = {file_byte, 8'd0};
        else if (hpos_next == 4'd11) tracks_next = {tracks_next[15:8], file_byte};
        if (hpos_next >= 4'd13) begin
          hpos_next = 4'd0;
          phase_next = (tracks_next == 16'd0) ? PH_DONE : PH_TRK_HDR;
        end else hpos_next = hpos_next + 4'd1;
      end
      PH_TRK_HDR: begin
        count = 1'b0;
        if (hpos_next >= 4'd4)
          acc_next = {(hpos_next == 4'd4) ? 24'd0 : acc_next[23:0], file_byte};
        if (hpos_next >= 4'd7) begin
          tbytes_next = acc_next;
          acc_next = 32'd0;
          hpos_next = 4'd0;
          if (tbytes_next == 32'd0) begin
            tracks_next = tracks_next - 16'd1;
            phase_next = (tracks_next == 16'd0) ? PH_DONE : PH_TRK_HDR;
          end else phase_next = PH_DELTA;
        end else hpos_next = hpos_next + 4'd1;
      end
      PH_DELTA: begin
        acc_next = {acc_next[24:0], file_byte[6:0]};
        if (!file_byte[7]) begin
          ticks_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          acc_next = 32'd0;
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        acc_next = 32'd0;
        if (file_byte == ST_META) phase_next = PH_META_TYPE;
        else if (file_byte == ST_SYSEX || file_byte == ST_SYSEX_E) phase_next = PH_LENGTH;
        else if (file_byte[7:4] == HI_NOTE_ON) phase_next = PH_NOTE_NUM;
        else if (file_byte[7:4] == HI_PROGRAM || file_byte[7:4] == HI_PRESS) begin
          skip_next = 32'd1;
          phase_next = PH_SKIP;
        end else begin
          skip_next = 32'd2;
          phase_next = PH_SKIP;
        end
      end
      PH_META_TYPE: begin
        acc_next = 32'd0;
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        acc_next = {acc_next[24:0], file_byte[6:0]};
        if (!file_byte[7]) begin
          skip_next = acc_next;
          acc_next = 32'd0;
          phase_next = (skip_next == 32'd0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_next = skip_next - 32'd1;
        if (skip_next == 32'd0) phase_next = PH_DELTA;
      end
      PH_NOTE_NUM: begin
        note_next = file_byte[6:0];
        phase_next = PH_NOTE_VEL;
      end
      PH_NOTE_VEL: begin
        evt_next = (file_byte != 8'd0) && record_enable;
        phase_next = PH_DELTA;
      end
      PH_DONE: count = 1'b0;
      default: count = 1'b0;
    endcase
    tb = tbytes_next - 32'd1;
    if (count) begin
      tbytes_next = tb;
      if (tb == 32'd0) begin
        tracks_next = tracks_next - 16'd1;
        hpos_next = 4'd0;
        phase_next = (tracks_next == 16'd0) ? PH_DONE : PH_TRK_HDR;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FILE_HDR;
      hpos <= '0; tracks <= '0; tbytes <= '0; acc <= '0; skip <= '0;
      ticks <= '0; note <= '0; evt_valid <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      hpos <= hpos_next; tracks <= tracks_next; tbytes <= tbytes_next;
      acc <= acc_next; skip <= skip_next; ticks <= ticks_next; note <= note_next;
      evt_valid <= evt_next || restart_next;
    end else evt_valid <= 1'b0;
  end

  // Event payload.
  always_ff @(posedge clk) begin
    if (take) begin
      evt.ticks <= ticks_next;
      evt.note <= note_next;
      evt.restart <= restart_next && !evt_next;
    end
  end

  // A restart and an event may coincide only when the restart byte is a
  // velocity byte, which cannot happen since a restart enters the header.
  a_evt_known: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> !$isunknown(evt.restart)) else $error("unknown event kind");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && take && !file_start) |=> phase == PH_DONE)
    else $error("left done without restart");
  a_start_hdr: assert property (@(posedge clk) disable iff (rst)
    (take && file_start) |=> (phase == PH_FILE_HDR && hpos == 4'd1))
    else $error("restart not taken as header byte");
endmodule

// ===== src/mfne_record.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Note record stage
// Drains the event queue, tracks slot and voice, divides by constants and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mfne_record (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  input  mfne_pkg::note_evt_t evt,
  output logic                room,
  output logic                valid,
  input  logic                stall,
  output logic [23:0]         time_slot,
  output logic [2:0]          voice_index,
  output logic [3:0]          pitch_class,
  output logic [3:0]          octave
);
  import mfne_pkg::*;

  localparam int Depth = 4;

  note_evt_t   q [Depth];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;
  logic        pop, s1_valid, s1_restart;
  logic [31:0] s1_ticks;
  logic [6:0]  s1_note;
  logic [63:0] prod;
  logic [25:0] pq;
  logic        s2_valid, s2_restart, s2_go;
  logic [25:0] s2_q;
  logic [6:0]  s2_note;
  logic [23:0] slot, last_slot;
  logic        last_valid;
  logic [2:0]  vc, vc_next;
  logic [7:0]  nsplit;

  // Split a note number into octave and pitch class by comparing it against
  // the multiples of twelve.
  function automatic logic [7:0] split_note(logic [6:0] n);
    logic [3:0] o;
    logic [6:0] base;
    o = 4'd0;
    for (int i = 1; i <= 10; i++) begin
      if (n >= 7'(12 * i)) o = 4'(i);
    end
    base = {3'd0, o} * 7'd12;
    return {o, 4'(n - base)};
  endfunction

  // Room while at least three slots remain: covers two items in flight plus one.
  assign room = (cnt <= 3'd1);
  assign s2_go = !valid || !stall;
  assign pop = (cnt != 3'd0) && s2_go;

  // Event queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (evt_valid) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'd0, evt_valid} - {2'd0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (evt_valid) q[wp] <= evt;
  end

  // Stage one: read queue.
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (s2_go) s1_valid <= pop;
  end
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ticks <= q[rp].ticks; s1_note <= q[rp].note; s1_restart <= q[rp].restart;
    end
  end

  // Stage two: ticks divided by 96 via reciprocal multiply (exact for 32 bits).
  assign prod = 64'(s1_ticks) * 64'd2863311531;
  assign pq = prod[63:38];
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (s2_go) s2_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (s2_go && s1_valid) begin
      s2_q <= pq; s2_note <= s1_note; s2_restart <= s1_restart;
    end
  end

  // Stage three: saturate, update voice tracking, register result.
  assign slot = (s2_q > 26'hFF_FFFF) ? 24'hFF_FFFF : s2_q[23:0];
  assign nsplit = split_note(s2_note);
  always_comb begin
    if (last_valid && slot == last_slot)
      vc_next = (vc < VOICE_MAX) ? vc + 3'd1 : VOICE_MAX;
    else vc_next = 3'd0;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0; last_valid <= 1'b0; last_slot <= '0; vc <= '0;
    end else if (s2_go) begin
      valid <= s2_valid && !s2_restart;
      if (s2_valid && s2_restart) begin
        last_valid <= 1'b0; last_slot <= '0; vc <= '0;
      end else if (s2_valid) begin
        last_valid <= 1'b1; last_slot <= slot; vc <= vc_next;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (s2_go && s2_valid && !s2_restart) begin
      time_slot <= slot;
      voice_index <= vc_next;
      pitch_class <= nsplit[3:0];
      octave <= nsplit[7:4];
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    !(evt_valid && cnt == 3'(Depth))) else $error("event queue overflow");
  a_voice_rng: assert property (@(posedge clk) disable iff (rst)
    valid |-> voice_index <= VOICE_MAX) else $error("voice index out of range");
  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    valid |-> (pitch_class < 4'd12 && octave < 4'd11)) else $error("bad note split");
endmodule

// ===== bench/midi_file_note_extractor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file note extractor testbench
// Feeds Standard MIDI File byte streams (well-formed files with random events,
// broken files and noise) through the parser, predicts the note records in a
// scoreboard of its own and compares every record field by field.
// ----------------------------------------------------------------------------
module midi_file_note_extractor_unit_tb;
  import mfne_pkg::*;

  typedef enum logic [3:0] {
    P_FILE_HDR, P_TRK_HDR, P_DELTA, P_STATUS, P_META_TYPE,
    P_LENGTH, P_SKIP, P_NOTE_NUM, P_NOTE_VEL, P_DONE
  } phase_e;

  typedef struct packed {
    logic [23:0] slot;
    logic [2:0]  voice;
    logic [3:0]  pc;
    logic [3:0]  oct;
  } note_rec_t;

  // Predicts the note records from the byte stream and holds them in order.
  class note_scoreboard;
    note_rec_t   pending[$];
    int          errors;
    logic        rec_en;
    phase_e      phase;
    logic [3:0]  hdr_pos;
    logic [15:0] tracks_left;
    logic [31:0] trk_left, acc, skip_left, ticks;
    logic [6:0]  note;
    logic [23:0] last_slot;
    logic        slot_seen;
    logic [2:0]  voices;

    function void clear_parser();
      phase = P_FILE_HDR; hdr_pos = 0; tracks_left = 0; trk_left = 0;
      acc = 0; skip_left = 0; ticks = 0; note = 0;
      last_slot = 0; slot_seen = 0; voices = 0;
    endfunction

    function void end_track();
      tracks_left = tracks_left - 16'd1;
      hdr_pos = 0;
      phase = (tracks_left == 0) ? P_DONE : P_TRK_HDR;
    endfunction

    function void begin_skip(logic [31:0] n);
      skip_left = n;
      phase = (n == 0) ? P_DELTA : P_SKIP;
    endfunction

    function void record_note();
      logic [31:0] q;
      logic [23:0] s;
      note_rec_t r;
      q = ticks / 96;
      s = (q > 32'hFFFFFF) ? 24'hFFFFFF : q[23:0];
      if (slot_seen && s == last_slot) begin
        if (voices < VOICE_MAX) voices++;
      end else begin
        last_slot = s; slot_seen = 1; voices = 0;
      end
      r.slot = last_slot; r.voice = voices;
      r.pc = 4'(note % 12); r.oct = 4'(note / 12);
      pending.push_back(r);
    endfunction

    // Notes one accepted byte and works out its record, if any.
    function void note_byte(logic [7:0] b, logic start);
      logic [32:0] sum;
      if (start) clear_parser();
      case (phase)
        P_FILE_HDR: begin
          if (hdr_pos == 10) tracks_left = {b, 8'h00};
          else if (hdr_pos == 11) tracks_left[7:0] = b;
          if (hdr_pos >= 13) begin
            hdr_pos = 0;
            phase = (tracks_left == 0) ? P_DONE : P_TRK_HDR;
          end else hdr_pos++;
          return;
        end
        P_TRK_HDR: begin
          if (hdr_pos == 4) acc = 0;
          if (hdr_pos >= 4) acc = {acc[23:0], b};
          if (hdr_pos >= 7) begin
            trk_left = acc; acc = 0; hdr_pos = 0;
            if (trk_left == 0) end_track();
            else phase = P_DELTA;
          end else hdr_pos++;
          return;
        end
        P_DELTA: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            sum = {1'b0, ticks} + acc;
            ticks = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            acc = 0; phase = P_STATUS;
          end
        end
        P_STATUS: begin
          acc = 0;
          if (b == ST_META) phase = P_META_TYPE;
          else if (b == ST_SYSEX || b == ST_SYSEX_E) phase = P_LENGTH;
          else if (b[7:4] == HI_NOTE_ON) phase = P_NOTE_NUM;
          else if (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESS) begin_skip(1);
          else begin_skip(2);
        end
        P_META_TYPE: begin acc = 0; phase = P_LENGTH; end
        P_LENGTH: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            skip_left = acc; acc = 0; begin_skip(skip_left);
          end
        end
        P_SKIP: begin
          skip_left--;
          if (skip_left == 0) phase = P_DELTA;
        end
        P_NOTE_NUM: begin note = b[6:0]; phase = P_NOTE_VEL; end
        P_NOTE_VEL: begin
          if (b != 0 && rec_en) record_note();
          phase = P_DELTA;
        end
        default: return;
      endcase
      trk_left--;
      if (trk_left == 0) end_track();
    endfunction

    function void check_record(note_rec_t got);
      note_rec_t e;
      if (pending.size() == 0) begin
        $error("unexpected record slot=%0d voice=%0d", got.slot, got.voice);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.slot != e.slot) begin
        $error("time_slot expected %0d actual %0d", e.slot, got.slot); errors++;
      end
      if (got.voice != e.voice) begin
        $error("voice_index expected %0d actual %0d", e.voice, got.voice); errors++;
      end
      if (got.pc != e.pc) begin
        $error("pitch_class expected %0d actual %0d", e.pc, got.pc); errors++;
      end
      if (got.oct != e.oct) begin
        $error("octave expected %0d actual %0d", e.oct, got.oct); errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall;
  logic [7:0]  file_byte = 0;
  logic        file_start = 0;
  logic        out_valid, out_stall = 0;
  logic [23:0] time_slot;
  logic [2:0]  voice_index;
  logic [3:0]  pitch_class, octave;
  logic        cfg_valid = 0, cfg_ready, cfg_data = 0;

  note_scoreboard sb = new();
  int  send_idle = 0, recv_stall = 0;
  int  cycles = 0;
  logic [7:0] stream[$];
  logic       starts[$];

  midi_file_note_extractor_unit uut (
    .clk, .rst, .in_valid, .in_stall, .file_byte, .file_start,
    .out_valid, .out_stall, .time_slot, .voice_index, .pitch_class, .octave,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #10 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("midi_file_note_extractor_unit_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls and record checking.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_record({time_slot, voice_index, pitch_class, octave});
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // Sends one byte, holding it until accepted.
  task automatic send_byte(logic [7:0] b, logic s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; file_byte <= b; file_start <= s;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, s);
  endtask

  task automatic flush_stream();
    while (stream.size() > 0) send_byte(stream.pop_front(), starts.pop_front());
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic put(logic [7:0] b);
    starts.push_back(stream.size() == 0 && starts.size() == 0 ? 1'b0 : 1'b0);
    stream.push_back(b);
  endtask

  task automatic put_vlq(logic [31:0] v);
    logic [7:0] parts[$];
    parts.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      parts.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (parts[i]) put(parts[i]);
  endtask

  task automatic put_header(logic [15:0] ntrk);
    put("M"); starts[starts.size() - 1] = 1;
    put("T"); put("h"); put("d"); put(0); put(0); put(0); put(6);
    put(0); put(1); put(ntrk[15:8]); put(ntrk[7:0]); put(8'h01); put(8'hE0);
  endtask

  // Builds a random track body and emits it with its length, at times cut short.
  task automatic put_track(int nev, bit big_delta);
    logic [7:0] body[$];
    logic [7:0] saved[$];
    logic       saved_s[$];
    int len, k;
    logic [31:0] d;
    saved = stream; saved_s = starts;
    stream = {}; starts = {};
    for (int e = 0; e < nev; e++) begin
      k = $urandom_range(9);
      d = big_delta ? $urandom : ($urandom_range(3) == 0 ? $urandom_range(400) : 0);
      put_vlq(d);
      if (k < 5) begin
        put(8'h90 | 8'($urandom_range(15))); put(8'($urandom));
        put($urandom_range(5) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
      end else if (k == 5) begin
        put(8'hC0 | 8'($urandom_range(31))); if (k == 5) put(8'($urandom));
      end else if (k == 6) begin
        put(ST_META); put(8'($urandom)); len = $urandom_range(3); put_vlq(len);
        repeat (len) put(8'($urandom));
      end else if (k == 7) begin
        put($urandom_range(1) ? ST_SYSEX : ST_SYSEX_E); len = $urandom_range(2);
        put_vlq(len); repeat (len) put(8'($urandom));
      end else begin
        put(8'($urandom)); put(8'($urandom)); put(8'($urandom));
      end
    end
    body = stream;
    stream = saved; starts = saved_s;
    len = body.size();
    if ($urandom_range(7) == 0 && len > 1) len = $urandom_range(1, len);
    put("M"); put("T"); put("r"); put("k");
    put(len[31:24]); put(len[23:16]); put(len[15:8]); put(len[7:0]);
    foreach (body[i]) put(body[i]);
  endtask

  task automatic wait_drain();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    cfg_valid <= 1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.rec_en = v;
    cfg_valid <= 0;
  endtask

  task automatic random_files(int nbytes);
    int ntrk;
    while (stream.size() < nbytes) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 20)) put(8'($urandom));
        if ($urandom_range(1)) starts[starts.size() - 1] = 1'($urandom);
      end else begin
        ntrk = $urandom_range(1, 3);
        put_header(16'(ntrk + ($urandom_range(5) == 0)));
        for (int t = 0; t < ntrk; t++) put_track($urandom_range(0, 12), $urandom_range(9) == 0);
      end
    end
    flush_stream();
  endtask

  initial begin
    sb.rec_en = 1;
    sb.clear_parser();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes of notes and deltas, note-on and pressure statuses,
    // velocity zero, empty track, zero tracks and a track cut mid-event.
    put_header(16'h0002);
    put("M"); put("T"); put("r"); put("k"); put(0); put(0); put(0); put(0);
    put("M"); put("T"); put("r"); put("k"); put(0); put(0); put(0); put(20);
    put(0); put(8'h90); put(8'h7F); put(8'hFF);
    put(0); put(8'h9F); put(8'h80); put(8'h01);
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F); put(8'h93); put(8'h3C); put(0);
    put(0); put(8'hD0); put(8'h55);
    put(0); put(8'h90); put(8'h40);
    flush_stream();
    put_header(16'h0000); put(8'h12); put(8'hFF);
    flush_stream();
    wait_drain();

    // Random phases through idling mixes and both register settings.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        3: begin send_idle = 17; recv_stall = 17; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      write_enable(ph != 3 ? 1'b1 : 1'b0);
      random_files(ph == 3 ? 50 : 140);
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("midi_file_note_extractor_unit_tb passed");
    else
      $display("midi_file_note_extractor_unit_tb failed");
    $finish;
  end
endmodule
